// File: sv/assert_macros.svh
// assertion macros shared by the rtl that carries checks
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds whenever the block is out of reset
`define CHK_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("check failed");

// check that also holds across reset
`define CHK_RESET(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("check failed");

`endif

// File: sv/ffha_pkg.sv
// package for the first fit heap allocator: defaults, state, command and status types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int ArenaBytesDefault  = 8192;
  localparam int HeaderBytesDefault = 24;
  localparam int OffsetW = 13;
  localparam int RequestW = 14;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ASPLIT,
    ST_AMARK,
    ST_FNRD,
    ST_FNCHK,
    ST_FWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic rd_cur;
    logic rd_nxt;
    logic latch_cur;
    logic advance;
    logic latch_nxt;
    logic wr_split;
    logic wr_mark;
    logic wr_free;
    logic set_ok;
    logic post;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic at_end;
    logic fit;
    logic spare;
    logic hit;
    logic past;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/ffha_ctrl.sv
// controller for the allocator: walks headers and sequences memory writes
// depends on ffha_pkg
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           kind,
  input  wire ffha_pkg::stat_t stat,
  output logic                in_ready,
  output ffha_pkg::cmd_t      cmd,
  output ffha_pkg::state_t    st
);

  ffha_pkg::state_t st_next;
  logic kind_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ffha_pkg::ST_INIT;
      kind_r <= ffha_pkg::KindAlloc;
    end else begin
      st <= st_next;
      if (in_valid && in_ready) kind_r <= kind;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ffha_pkg::ST_INIT: st_next = ffha_pkg::ST_IDLE;
      ffha_pkg::ST_IDLE: if (in_valid) st_next = ffha_pkg::ST_RD;
      ffha_pkg::ST_RD: st_next = stat.at_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_CHK;
      ffha_pkg::ST_CHK: begin
        if (kind_r == ffha_pkg::KindAlloc) begin
          if (stat.fit) st_next = stat.spare ? ffha_pkg::ST_ASPLIT : ffha_pkg::ST_AMARK;
          else st_next = ffha_pkg::ST_RD;
        end else begin
          if (stat.hit) st_next = stat.is_free ? ffha_pkg::ST_DONE : ffha_pkg::ST_FNRD;
          else if (stat.past) st_next = ffha_pkg::ST_DONE;
          else st_next = ffha_pkg::ST_RD;
        end
      end
      ffha_pkg::ST_ASPLIT: st_next = ffha_pkg::ST_AMARK;
      ffha_pkg::ST_AMARK: st_next = ffha_pkg::ST_DONE;
      ffha_pkg::ST_FNRD: st_next = ffha_pkg::ST_FNCHK;
      ffha_pkg::ST_FNCHK: st_next = ffha_pkg::ST_FWR;
      ffha_pkg::ST_FWR: st_next = ffha_pkg::ST_DONE;
      ffha_pkg::ST_DONE: if (stat.out_free) st_next = ffha_pkg::ST_IDLE;
      default: st_next = ffha_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (st)
      ffha_pkg::ST_INIT: cmd.init = 1'b1;
      ffha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ffha_pkg::ST_RD: cmd.rd_cur = 1'b1;
      ffha_pkg::ST_CHK: begin
        cmd.latch_cur = 1'b1;
        if (kind_r == ffha_pkg::KindAlloc) cmd.advance = !stat.fit;
        else cmd.advance = !stat.hit && !stat.past;
      end
      ffha_pkg::ST_ASPLIT: cmd.wr_split = 1'b1;
      ffha_pkg::ST_AMARK: begin
        cmd.wr_mark = 1'b1;
        cmd.set_ok = 1'b1;
      end
      ffha_pkg::ST_FNRD: cmd.rd_nxt = 1'b1;
      ffha_pkg::ST_FNCHK: cmd.latch_nxt = 1'b1;
      ffha_pkg::ST_FWR: begin
        cmd.wr_free = 1'b1;
        cmd.set_ok = 1'b1;
      end
      ffha_pkg::ST_DONE: cmd.post = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/ffha_dp.sv
// datapath for the allocator: header memory, walk registers, result register
// depends on ffha_pkg
`timescale 1ns / 1ps
`default_nettype none
module ffha_dp #(
  parameter int ARENA_BYTES  = ffha_pkg::ArenaBytesDefault,
  parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ffha_pkg::cmd_t                 cmd,
  input  wire logic                           kind,
  input  wire logic [ffha_pkg::RequestW-1:0]  request_bytes,
  input  wire logic [ffha_pkg::OffsetW-1:0]   payload_offset,
  input  wire logic                           out_ready,
  output ffha_pkg::stat_t                     stat,
  output logic                                out_valid,
  output logic                                ok,
  output logic [ffha_pkg::OffsetW-1:0]        granted_offset
);

  localparam int AW = $clog2(ARENA_BYTES + 1);
  localparam int W = ((AW > ffha_pkg::RequestW) ? AW : ffha_pkg::RequestW) + 1;
  localparam int Depth = ARENA_BYTES / 8;
  localparam int IW = $clog2(Depth);
  localparam logic [W-1:0] Hdr = W'(HEADER_BYTES);
  localparam logic [W-1:0] Arena = W'(ARENA_BYTES);

  logic [W:0] mem [Depth];
  logic [W:0] rdata;

  logic           kind_r, res_ok, spare_r;
  logic [W-1:0]   req, off, cur, cur_size, prev_start, prev_size, nxt_size;
  logic           prev_free, prev_valid, nxt_free;
  logic [W-1:0]   rd_addr, wr_addr, wr_size, hit_addr, nxt_addr, fsz;
  logic           wr_en, wr_free_bit;
  logic [W-1:0]   rsize;
  logic           rfree;

  assign rfree = rdata[W];
  assign rsize = rdata[W-1:0];
  assign hit_addr = cur + Hdr;
  assign nxt_addr = cur + Hdr + cur_size;
  assign fsz = cur_size + (nxt_free ? (Hdr + nxt_size) : '0);

  assign stat.is_free  = rfree;
  assign stat.at_end   = cur >= Arena;
  assign stat.fit      = rfree && (rsize >= req);
  assign stat.spare    = (rsize - req) >= Hdr;
  assign stat.hit      = hit_addr == off;
  assign stat.past     = hit_addr > off;
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    rd_addr = cmd.rd_nxt ? nxt_addr : cur;
    wr_en = 1'b1;
    wr_free_bit = 1'b1;
    wr_addr = cur;
    wr_size = cur_size;
    if (cmd.init) begin
      wr_addr = '0;
      wr_size = Arena - Hdr;
    end else if (cmd.wr_split) begin
      wr_addr = cur + Hdr + req;
      wr_size = cur_size - req - Hdr;
    end else if (cmd.wr_mark) begin
      wr_free_bit = 1'b0;
      wr_size = spare_r ? req : cur_size;
    end else if (cmd.wr_free) begin
      if (prev_valid && prev_free) begin
        wr_addr = prev_start;
        wr_size = prev_size + Hdr + fsz;
      end else begin
        wr_size = fsz;
      end
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[IW+2:3]] <= {wr_free_bit, wr_size};
    rdata <= mem[rd_addr[IW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      req <= (W'(request_bytes) + W'(7)) & ~W'(7);
      off <= W'(payload_offset);
      cur <= '0;
      prev_valid <= 1'b0;
      res_ok <= 1'b0;
    end
    if (cmd.latch_cur) begin
      cur_size <= rsize;
      spare_r <= stat.spare;
    end
    if (cmd.advance) begin
      prev_start <= cur;
      prev_size <= rsize;
      prev_free <= rfree;
      prev_valid <= 1'b1;
      cur <= cur + Hdr + rsize;
    end
    if (cmd.latch_nxt) begin
      nxt_size <= rsize;
      nxt_free <= rfree && (nxt_addr < Arena);
    end
    if (cmd.set_ok) res_ok <= 1'b1;
    if (cmd.post) begin
      ok <= res_ok;
      if (kind_r == ffha_pkg::KindFree) granted_offset <= off[ffha_pkg::OffsetW-1:0];
      else if (res_ok) granted_offset <= hit_addr[ffha_pkg::OffsetW-1:0];
      else granted_offset <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.post) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule
`default_nettype wire

// File: sv/first_fit_heap_allocator.sv
// top level of the first fit heap allocator: controller plus datapath
// depends on ffha_pkg, ffha_ctrl, ffha_dp, assert_macros.svh
//
// channel   signals                                   direction
// in        in_valid in_ready kind request_bytes      request
//           payload_offset
// out       out_valid out_ready ok granted_offset     result
//
// each transaction walks the block headers in address order, with one memory read
// and one check for each header visited, then does its writes and hands the
// result over; one header memory port sets the pace
// after reset the init state writes the initial free block before in_ready rises
// a stalled result holds the block in its final state until taken
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module first_fit_heap_allocator #(
  parameter int ARENA_BYTES  = ffha_pkg::ArenaBytesDefault,
  parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [ffha_pkg::RequestW-1:0] request_bytes,
  input  wire logic [ffha_pkg::OffsetW-1:0]  payload_offset,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               ok,
  output logic [ffha_pkg::OffsetW-1:0]       granted_offset
);

  ffha_pkg::cmd_t   cmd;
  ffha_pkg::stat_t  stat;
  ffha_pkg::state_t st;

  ffha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .kind(kind), .stat(stat),
    .in_ready(in_ready), .cmd(cmd), .st(st)
  );

  ffha_dp #(.ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .kind(kind), .request_bytes(request_bytes),
    .payload_offset(payload_offset), .out_ready(out_ready), .stat(stat),
    .out_valid(out_valid), .ok(ok), .granted_offset(granted_offset)
  );

  `CHK_ALWAYS(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `CHK_RESET(a_init_after_reset, clk, $past(rst) |-> !in_ready)
  `CHK_ALWAYS(a_post_needs_slot, clk, rst, cmd.post |-> (!out_valid || out_ready))
  `CHK_ALWAYS(a_ready_only_idle, clk, rst, in_ready |-> (st == ffha_pkg::ST_IDLE))

endmodule
`default_nettype wire

// File: tb/sv/first_fit_heap_allocator_tb.sv
// testbench for first_fit_heap_allocator: directed and random allocate/free traffic
// depends on ffha_pkg and the allocator rtl; predicts results with its own block list
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_tb;

  localparam int Arena = ffha_pkg::ArenaBytesDefault;
  localparam int Hdr = ffha_pkg::HeaderBytesDefault;
  localparam int MaxBlocks = Arena / 8;
  localparam int CycleLimit = 4000000;

  typedef struct {
    int unsigned start;
    int unsigned size;
    bit is_free;
  } heap_block_t;

  typedef struct packed {
    logic ok;
    logic [ffha_pkg::OffsetW-1:0] off;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = ffha_pkg::KindAlloc;
  logic [ffha_pkg::RequestW-1:0] request_bytes = '0;
  logic [ffha_pkg::OffsetW-1:0] payload_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok;
  logic [ffha_pkg::OffsetW-1:0] granted_offset;

  heap_block_t heap[$];
  alloc_result_t expected_results[$];
  int unsigned live_offsets[$];
  int errors = 0;
  int cycles = 0;
  bit stall_enable = 1'b1;
  int sink_hold = 0;

  always #2 clk = ~clk;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .request_bytes(request_bytes), .payload_offset(payload_offset),
    .out_valid(out_valid), .out_ready(out_ready), .ok(ok), .granted_offset(granted_offset)
  );

  function automatic alloc_result_t predict_alloc(int unsigned request);
    alloc_result_t r;
    int unsigned req;
    int unsigned spare;
    heap_block_t nb;
    req = (request + 7) & ~32'd7;
    r = '0;
    foreach (heap[i]) begin
      if (heap[i].is_free && heap[i].size >= req) begin
        spare = heap[i].size - req;
        if (spare >= Hdr && heap.size() < MaxBlocks) begin
          nb.start = heap[i].start + Hdr + req;
          nb.size = spare - Hdr;
          nb.is_free = 1'b1;
          heap.insert(i + 1, nb);
          heap[i].size = req;
        end
        heap[i].is_free = 1'b0;
        r.ok = 1'b1;
        r.off = ffha_pkg::OffsetW'(heap[i].start + Hdr);
        return r;
      end
    end
    return r;
  endfunction

  function automatic alloc_result_t predict_free(int unsigned off);
    alloc_result_t r;
    r.ok = 1'b0;
    r.off = ffha_pkg::OffsetW'(off);
    foreach (heap[i]) begin
      if (!heap[i].is_free && heap[i].start + Hdr == off) begin
        heap[i].is_free = 1'b1;
        if (i + 1 < heap.size() && heap[i + 1].is_free) begin
          heap[i].size += Hdr + heap[i + 1].size;
          heap.delete(i + 1);
        end
        if (i > 0 && heap[i - 1].is_free) begin
          heap[i - 1].size += Hdr + heap[i].size;
          heap.delete(i);
        end
        r.ok = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic idle_burst();
    if (stall_enable && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  // one transaction on the request channel
  task automatic send_item(input logic k, input int unsigned req, input int unsigned off);
    alloc_result_t r;
    int unsigned req_m;
    int unsigned off_m;
    req_m = req & ((1 << ffha_pkg::RequestW) - 1);
    off_m = off & ((1 << ffha_pkg::OffsetW) - 1);
    idle_burst();
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    request_bytes <= ffha_pkg::RequestW'(req_m);
    payload_offset <= ffha_pkg::OffsetW'(off_m);
    if (k == ffha_pkg::KindAlloc) begin
      r = predict_alloc(req_m);
      if (r.ok) live_offsets.push_back(r.off);
    end else begin
      r = predict_free(off_m);
    end
    expected_results.push_back(r);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_alloc(input int unsigned req);
    send_item(ffha_pkg::KindAlloc, req, $urandom_range(0, 8191));
  endtask

  task automatic free_random_live();
    int idx;
    int unsigned off;
    idx = $urandom_range(0, live_offsets.size() - 1);
    off = live_offsets[idx];
    live_offsets.delete(idx);
    send_item(ffha_pkg::KindFree, $urandom_range(0, 16383), off);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // result side: ready, with random idle bursts while stalls are enabled
  always @(negedge clk) begin
    if (!stall_enable) begin
      out_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else if (out_ready && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      sink_hold = $urandom_range(1, 18) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_results.pop_front();
        if (ok !== e.ok) report_mismatch($sformatf("ok %b expected %b", ok, e.ok));
        if (granted_offset !== e.off)
          report_mismatch($sformatf("offset %0d expected %0d", granted_offset, e.off));
      end
    end
  end

  task automatic test_edges();
    send_alloc(0);
    send_alloc(1);
    send_alloc(8);
    send_alloc(16383);
    send_alloc(8192);
    send_alloc(Arena - 3 * Hdr - 40);
    send_alloc(48);
    send_item(ffha_pkg::KindFree, 0, 0);
    send_item(ffha_pkg::KindFree, 16383, 8191);
    send_item(ffha_pkg::KindFree, 0, 5);
    while (live_offsets.size() != 0) free_random_live();
    send_alloc(Arena - Hdr);
    send_alloc(0);
    free_random_live();
    send_alloc(Arena - 2 * Hdr - 16);
    send_alloc(8);
    while (live_offsets.size() != 0) free_random_live();
  endtask

  task automatic test_fill_list();
    // medium blocks until the arena runs out
    repeat (60) send_alloc($urandom_range(64, 200));
    drain();
    while (live_offsets.size() != 0) free_random_live();
  endtask

  task automatic test_random(input int n);
    repeat (n) begin
      if (live_offsets.size() != 0 && $urandom_range(0, 1)) free_random_live();
      else if ($urandom_range(0, 19) == 0) send_item(ffha_pkg::KindFree, $urandom, $urandom);
      else if ($urandom_range(0, 9) == 0) send_alloc($urandom_range(0, 16383));
      else send_alloc($urandom_range(0, 600));
    end
  endtask

  initial begin
    heap.push_back('{start: 0, size: Arena - Hdr, is_free: 1'b1});
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edges();
    drain();
    test_fill_list();
    test_random(320);
    drain();
    stall_enable = 1'b0;
    test_random(150);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
